### design/adts_pkg.sv
`timescale 1ns / 1ps
package adts_pkg;

   localparam int BYTE_WIDTH      = 8;
   localparam int OUT_TIME_WIDTH  = 48;
   localparam int HPOS_WIDTH      = 4;
   localparam int HDR_BYTES       = 9;
   localparam int TAG_LEN_WIDTH   = 28;
   localparam int FRAME_LEN_WIDTH = 13;
   localparam int RATE_WIDTH      = 4;
   localparam int DUR_WIDTH       = 17;
   localparam int RATE_COUNT      = 12;

   localparam int QUEUE_DEPTH       = 2;
   localparam int QUEUE_PTR_WIDTH   = 1;
   localparam int QUEUE_COUNT_WIDTH = 2;

   localparam logic [7:0] SYNC_BYTE     = 8'hFF;
   localparam logic [7:0] SYNC2_MASK    = 8'hF6;
   localparam logic [7:0] SYNC2_VALUE   = 8'hF0;
   localparam logic [7:0] ID3_I         = 8'h49;
   localparam logic [7:0] ID3_D         = 8'h44;
   localparam logic [7:0] ID3_3         = 8'h33;

   localparam logic [HPOS_WIDTH-1:0] HPOS_SYNC1   = 4'd0;
   localparam logic [HPOS_WIDTH-1:0] HPOS_SYNC2   = 4'd1;
   localparam logic [HPOS_WIDTH-1:0] HPOS_RATE    = 4'd2;
   localparam logic [HPOS_WIDTH-1:0] HPOS_CHAN    = 4'd3;
   localparam logic [HPOS_WIDTH-1:0] HPOS_LEN_MID = 4'd4;
   localparam logic [HPOS_WIDTH-1:0] HPOS_LEN_LO  = 4'd5;
   localparam logic [HPOS_WIDTH-1:0] HPOS_TAG_B0  = 4'd6;
   localparam logic [HPOS_WIDTH-1:0] HPOS_TAG_B1  = 4'd7;
   localparam logic [HPOS_WIDTH-1:0] HPOS_TAG_B2  = 4'd8;
   localparam logic [HPOS_WIDTH-1:0] HPOS_TAG_END = 4'd9;
   localparam logic [HPOS_WIDTH-1:0] HDR_SIZE_PLAIN = 4'd7;
   localparam logic [HPOS_WIDTH-1:0] HDR_SIZE_CRC   = 4'd9;

   typedef enum logic [2:0] {
      PH_EXPECT,
      PH_TAG_HDR,
      PH_TAG_SKIP,
      PH_HDR,
      PH_PAYLOAD
   } phase_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] stream_byte;
      logic                  stream_start;
   } req_item_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0]     payload_byte;
      logic                      first_of_frame;
      logic                      last_of_frame;
      logic [OUT_TIME_WIDTH-1:0] frame_time_us;
      logic [1:0]                profile;
      logic [RATE_WIDTH-1:0]     rate_index;
      logic [2:0]                channel_config;
      logic                      status;
   } rsp_item_type;

   // ceil(1024 * 1000000 / rate) in microseconds
   function automatic logic [DUR_WIDTH-1:0] frame_duration(input logic [RATE_WIDTH-1:0] idx);
      logic [DUR_WIDTH-1:0] dur;
      unique case (idx)
         4'd0:    dur = 17'd10667;
         4'd1:    dur = 17'd11610;
         4'd2:    dur = 17'd16000;
         4'd3:    dur = 17'd21334;
         4'd4:    dur = 17'd23220;
         4'd5:    dur = 17'd32000;
         4'd6:    dur = 17'd42667;
         4'd7:    dur = 17'd46440;
         4'd8:    dur = 17'd64000;
         4'd9:    dur = 17'd85334;
         4'd10:   dur = 17'd92880;
         4'd11:   dur = 17'd128000;
         default: dur = '0;
      endcase
      return dur;
   endfunction

   function automatic logic [HPOS_WIDTH-1:0] head_size(input logic crc);
      return crc ? HDR_SIZE_CRC : HDR_SIZE_PLAIN;
   endfunction

endpackage

### design/adts_req_if.sv
`timescale 1ns / 1ps
interface adts_req_if import adts_pkg::*; ();
   logic         valid;
   logic         ready;
   req_item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

### design/adts_rsp_if.sv
`timescale 1ns / 1ps
interface adts_rsp_if import adts_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

### design/adts_front.sv
`timescale 1ns / 1ps
module adts_front import adts_pkg::*; #(
   parameter int TIME_WIDTH = 48
) (
   input logic        clock,
   input logic        reset,
   adts_req_if.sink   req_ch,
   adts_rsp_if.source res_ch
);

   phase_type                  phase_ff, phase_in, cur_phase;
   logic [HPOS_WIDTH-1:0]      hpos_ff, hpos_in, cur_hpos;
   logic [TAG_LEN_WIDTH-1:0]   tag_left_ff, tag_left_in, cur_tag_left;
   logic [FRAME_LEN_WIDTH-1:0] left_ff, left_in, cur_left;
   logic                       crc_ff, crc_in, cur_crc;
   logic [RATE_WIDTH-1:0]      rate_ff, rate_in, cur_rate;
   logic                       locked_ff, locked_in, cur_locked;
   logic [TIME_WIDTH-1:0]      time_ff, time_in, cur_time;
   logic                       halted_ff, halted_in, cur_halted;
   logic                       first_ff, first_in, cur_first;
   logic [BYTE_WIDTH-1:0]      hdr_ff [HDR_BYTES];

   logic                       accept;
   logic                       start;
   logic [BYTE_WIDTH-1:0]      b;
   logic [FRAME_LEN_WIDTH-1:0] frame_len;
   logic [HPOS_WIDTH-1:0]      hsize_now;
   logic [RATE_WIDTH-1:0]      new_rate;
   logic                       err;
   logic                       emit;
   logic                       hdr_we;
   logic [HPOS_WIDTH-1:0]      hdr_idx;
   rsp_item_type               item;

   assign req_ch.ready = res_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign start        = req_ch.item.stream_start;
   assign b            = req_ch.item.stream_byte;

   // a stream start clears all state but the stored header bytes before this byte is looked at
   assign cur_phase    = start ? PH_EXPECT : phase_ff;
   assign cur_hpos     = start ? '0 : hpos_ff;
   assign cur_tag_left = start ? '0 : tag_left_ff;
   assign cur_left     = start ? '0 : left_ff;
   assign cur_crc      = start ? 1'b0 : crc_ff;
   assign cur_rate     = start ? '0 : rate_ff;
   assign cur_locked   = start ? 1'b0 : locked_ff;
   assign cur_time     = start ? '0 : time_ff;
   assign cur_halted   = start ? 1'b0 : halted_ff;
   assign cur_first    = start ? 1'b0 : first_ff;

   assign frame_len = {hdr_ff[HPOS_CHAN][1:0], hdr_ff[HPOS_LEN_MID], b[7:5]};
   assign hsize_now = head_size(cur_crc);
   assign new_rate  = b[5:2];

   // classify
   always_comb begin
      err  = 1'b0;
      emit = 1'b0;
      if (!cur_halted) begin
         unique case (cur_phase)
            PH_EXPECT: err = (b != ID3_I) && (b != SYNC_BYTE);
            PH_TAG_HDR: err = (cur_hpos == HPOS_SYNC2 && b != ID3_D) ||
                              (cur_hpos == HPOS_RATE && b != ID3_3);
            PH_TAG_SKIP: err = 1'b0;
            PH_HDR: err = (cur_hpos == HPOS_SYNC1 && b != SYNC_BYTE) ||
                          (cur_hpos == HPOS_SYNC2 && (b & SYNC2_MASK) != SYNC2_VALUE) ||
                          (cur_hpos == HPOS_RATE && !cur_locked &&
                           new_rate >= RATE_WIDTH'(RATE_COUNT)) ||
                          (cur_hpos == HPOS_LEN_LO && frame_len < FRAME_LEN_WIDTH'(hsize_now));
            PH_PAYLOAD: emit = 1'b1;
            default: err = 1'b0;
         endcase
      end
   end

   // next state
   always_comb begin
      phase_in    = cur_phase;
      hpos_in     = cur_hpos;
      tag_left_in = cur_tag_left;
      left_in     = cur_left;
      crc_in      = cur_crc;
      rate_in     = cur_rate;
      locked_in   = cur_locked;
      time_in     = cur_time;
      halted_in   = cur_halted;
      first_in    = cur_first;
      hdr_we      = 1'b0;
      hdr_idx     = cur_hpos;
      if (err) begin
         halted_in = 1'b1;
      end else if (!cur_halted) begin
         unique case (cur_phase)
            PH_EXPECT: begin
               hdr_we  = 1'b1;
               hdr_idx = HPOS_SYNC1;
               hpos_in = HPOS_SYNC2;
               phase_in = (b == ID3_I) ? PH_TAG_HDR : PH_HDR;
            end
            PH_TAG_HDR: begin
               if (cur_hpos < HPOS_TAG_END) begin
                  hdr_we  = 1'b1;
                  hpos_in = cur_hpos + 1'b1;
               end else begin
                  tag_left_in = {hdr_ff[HPOS_TAG_B0][6:0], hdr_ff[HPOS_TAG_B1][6:0],
                                 hdr_ff[HPOS_TAG_B2][6:0], b[6:0]};
                  hpos_in     = '0;
                  phase_in    = (tag_left_in != '0) ? PH_TAG_SKIP : PH_EXPECT;
               end
            end
            PH_TAG_SKIP: begin
               tag_left_in = cur_tag_left - 1'b1;
               if (cur_tag_left == TAG_LEN_WIDTH'(1)) begin
                  phase_in = PH_EXPECT;
               end
            end
            PH_HDR: begin
               hdr_we = 1'b1;
               if (cur_hpos == HPOS_SYNC2) begin
                  crc_in = ~b[0];
               end
               if (cur_hpos == HPOS_RATE && !cur_locked) begin
                  rate_in   = new_rate;
                  locked_in = 1'b1;
               end
               if (cur_hpos == HPOS_LEN_LO) begin
                  left_in = frame_len - FRAME_LEN_WIDTH'(hsize_now);
               end
               if (cur_hpos + 1'b1 < head_size(crc_in)) begin
                  hpos_in = cur_hpos + 1'b1;
               end else begin
                  hpos_in = '0;
                  if (left_in == '0) begin
                     time_in = cur_time + TIME_WIDTH'(frame_duration(cur_rate));
                  end else begin
                     phase_in = PH_PAYLOAD;
                     first_in = 1'b1;
                  end
               end
            end
            PH_PAYLOAD: begin
               first_in = 1'b0;
               left_in  = cur_left - 1'b1;
               if (cur_left == FRAME_LEN_WIDTH'(1)) begin
                  time_in  = cur_time + TIME_WIDTH'(frame_duration(cur_rate));
                  phase_in = PH_HDR;
                  hpos_in  = '0;
               end
            end
            default: begin
               phase_in = PH_EXPECT;
               hpos_in  = '0;
            end
         endcase
      end
   end

   // outputs
   always_comb begin
      item = '0;
      item.frame_time_us = OUT_TIME_WIDTH'(cur_time);
      item.rate_index    = cur_rate;
      if (err) begin
         item.status = 1'b1;
      end else begin
         item.payload_byte   = b;
         item.first_of_frame = cur_first;
         item.last_of_frame  = (cur_left <= FRAME_LEN_WIDTH'(1));
         item.profile        = hdr_ff[HPOS_RATE][7:6];
         item.channel_config = {hdr_ff[HPOS_RATE][0], hdr_ff[HPOS_CHAN][7:6]};
      end
   end

   assign res_ch.valid = accept && (err || emit);
   assign res_ch.item  = item;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_EXPECT;
         hpos_ff     <= '0;
         tag_left_ff <= '0;
         left_ff     <= '0;
         crc_ff      <= 1'b0;
         rate_ff     <= '0;
         locked_ff   <= 1'b0;
         time_ff     <= '0;
         halted_ff   <= 1'b0;
         first_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         hpos_ff     <= hpos_in;
         tag_left_ff <= tag_left_in;
         left_ff     <= left_in;
         crc_ff      <= crc_in;
         rate_ff     <= rate_in;
         locked_ff   <= locked_in;
         time_ff     <= time_in;
         halted_ff   <= halted_in;
         first_ff    <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && hdr_we && !err) begin
         hdr_ff[hdr_idx] <= b;
      end
   end

endmodule

### design/adts_queue.sv
`timescale 1ns / 1ps
module adts_queue import adts_pkg::*; (
   input logic        clock,
   input logic        reset,
   adts_rsp_if.sink   in_ch,
   adts_rsp_if.source out_ch
);

   rsp_item_type                 slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_WIDTH-1:0] count_ff, count_in;
   logic                         push;
   logic                         pop;

   assign in_ch.ready  = (count_ff != QUEUE_COUNT_WIDTH'(QUEUE_DEPTH));
   assign out_ch.valid = (count_ff != '0);
   assign out_ch.item  = slot_ff[rd_ptr_ff];

   assign push = in_ch.valid && in_ch.ready;
   assign pop  = out_ch.valid && out_ch.ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_ch.item;
      end
   end

endmodule

### design/adts_back.sv
`timescale 1ns / 1ps
module adts_back import adts_pkg::*; (
   input logic        clock,
   input logic        reset,
   adts_rsp_if.sink   in_ch,
   adts_rsp_if.source out_ch
);

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;
   logic         load;

   assign in_ch.ready  = !valid_ff || out_ch.ready;
   assign load         = in_ch.valid && in_ch.ready;
   assign out_ch.valid = valid_ff;
   assign out_ch.item  = item_ff;

   always_comb begin
      priority if (load) begin
         valid_in = 1'b1;
      end else if (out_ch.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= in_ch.item;
      end
   end

endmodule

### design/adts_stream_deframer.sv
`timescale 1ns / 1ps
// ADTS stream deframer. Takes one stream byte per cycle on req_ch and returns each AAC payload
// byte on rsp_ch with frame marks, header fields and a microsecond frame time; leading ID3v2
// tags and ADTS headers give no result. A header error gives one result with status set, after
// which bytes are taken and dropped until one arrives with stream_start set. A byte is parsed in
// the cycle it is taken; its result passes a two-entry queue and then an output register before
// it appears on rsp_ch. Bytes keep flowing at one per cycle while results are being taken;
// req_ch.ready falls only once the queue is full.
module adts_stream_deframer import adts_pkg::*; #(
   parameter int TIME_WIDTH = 48
) (
   input logic        clock,
   input logic        reset,
   adts_req_if.sink   req_ch,
   adts_rsp_if.source rsp_ch
);

   adts_rsp_if front_q ();
   adts_rsp_if q_back ();

   adts_front #(
      .TIME_WIDTH(TIME_WIDTH)
   ) u_front (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .res_ch(front_q.source)
   );

   adts_queue u_queue (
      .clock (clock),
      .reset (reset),
      .in_ch (front_q.sink),
      .out_ch(q_back.source)
   );

   adts_back u_back (
      .clock (clock),
      .reset (reset),
      .in_ch (q_back.sink),
      .out_ch(rsp_ch)
   );

   a_push_taken: assert property (@(posedge clock) disable iff (reset)
      front_q.valid |-> front_q.ready)
      else $error("result pushed while queue full");

   a_halt_after_error: assert property (@(posedge clock) disable iff (reset)
      front_q.valid && front_q.item.status |=> !front_q.valid || req_ch.item.stream_start)
      else $error("result produced after header error without stream start");

   a_rate_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.item.status |-> rsp_ch.item.rate_index < RATE_WIDTH'(RATE_COUNT))
      else $error("payload item with unlocked rate index");

endmodule
